// ===== design/multichannel_moving_average_macros.svh =====
`ifndef MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH

// checked only while out of reset
`define MMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define MMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/mma_pkg.sv =====
`timescale 1ns / 1ps

package mma_pkg;

  localparam int CHANNELS   = 4;
  localparam int WINDOW     = 5;
  localparam int SAMPLE_W   = 12;
  localparam int SCALED_W   = 16;
  localparam int FULL_SCALE = 4095;
  localparam int Q15_ONE    = 32768;

  localparam int SUM_W       = $clog2(WINDOW * FULL_SCALE + 1);
  localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DIV_W       = $clog2(WINDOW + 1);
  localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // s * 32768 / 4095 = t + t / 4095 with t = 8 * s
  localparam int GAIN_SHIFT   = $clog2(Q15_ONE / (FULL_SCALE + 1));
  localparam int TERM_W       = SAMPLE_W + GAIN_SHIFT;
  localparam int FRAC_SHIFT   = TERM_W + SAMPLE_W;
  localparam int FRAC_RECIP   = ((1 << FRAC_SHIFT) + FULL_SCALE - 1) / FULL_SCALE;
  localparam int FRAC_RECIP_W = $clog2(FRAC_RECIP + 1);
  localparam int FRAC_PROD_W  = TERM_W + FRAC_RECIP_W;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_ch0;
    logic [SAMPLE_W-1:0] sample_ch1;
    logic [SAMPLE_W-1:0] sample_ch2;
    logic [SAMPLE_W-1:0] sample_ch3;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average_ch0;
    logic [SAMPLE_W-1:0] average_ch1;
    logic [SAMPLE_W-1:0] average_ch2;
    logic [SAMPLE_W-1:0] average_ch3;
    logic [SCALED_W-1:0] scaled_ch0;
    logic [SCALED_W-1:0] scaled_ch1;
    logic [SCALED_W-1:0] scaled_ch2;
    logic [SCALED_W-1:0] scaled_ch3;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] slot;
    logic [RECIP_W-1:0] recip;
  } lane_ctrl_t;

endpackage

// ===== design/multichannel_moving_average.sv =====
// an accepted item is registered by the lane update, then by the output register
// throughput: 1 item per cycle while the output side takes results
// the shared window pointer and each lane's sum update in the same cycle
// reset clears all histories, sums, the window pointer and the filled flag at once
// no clearing pass: the block takes items from the first cycle after reset
`timescale 1ns / 1ps

module multichannel_moving_average (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mma_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mma_pkg::out_item_t out_item_o
);
  import mma_pkg::*;

  lane_ctrl_t          lane_ctrl;
  logic                pipe_valid;
  logic                pipe_ready;
  logic [SAMPLE_W-1:0] samples [CHANNELS];
  logic [SAMPLE_W-1:0] averages [CHANNELS];
  logic [SCALED_W-1:0] scaled [CHANNELS];

  assign samples[0] = in_item_i.sample_ch0;
  assign samples[1] = in_item_i.sample_ch1;
  assign samples[2] = in_item_i.sample_ch2;
  assign samples[3] = in_item_i.sample_ch3;

  mma_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pipe_valid_o (pipe_valid),
    .pipe_ready_i (pipe_ready),
    .lane_ctrl_o  (lane_ctrl)
  );

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    mma_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .lane_ctrl_i (lane_ctrl),
      .sample_i    (samples[ch]),
      .average_o   (averages[ch]),
      .scaled_o    (scaled[ch])
    );
  end

  mma_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pipe_valid_i (pipe_valid),
    .pipe_ready_o (pipe_ready),
    .average_i    (averages),
    .scaled_i     (scaled),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

// ===== design/mma_ctrl.sv =====
`timescale 1ns / 1ps

module mma_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               pipe_valid_o,
  input  logic               pipe_ready_i,
  output mma_pkg::lane_ctrl_t lane_ctrl_o
);
  import mma_pkg::*;

  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic               full_q, full_d;
  logic [RECIP_W-1:0] recip_q, recip_d;
  logic               valid_q, valid_d;
  logic               accept;
  logic [SLOT_W-1:0]  slot_next;
  logic               full_next;
  logic [DIV_W-1:0]   divisor;
  logic [RECIP_W-1:0] recip_tab [2**DIV_W];

  // ceil(2^RECIP_SHIFT / d) gives an exact floor division for every window sum
  for (genvar Div = 0; Div < 2**DIV_W; Div++) begin : g_recip
    if (Div >= 1 && Div <= WINDOW) begin : g_used
      localparam logic [RECIP_W-1:0] RecipVal =
        RECIP_W'(((longint'(1) << RECIP_SHIFT) + Div - 1) / Div);
      assign recip_tab[Div] = RecipVal;
    end else begin : g_unused
      assign recip_tab[Div] = '0;
    end
  end

  assign in_ready_o   = !valid_q || pipe_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign pipe_valid_o = valid_q;

  always_comb begin
    slot_next = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
    full_next = full_q || (slot_next == '0);
    divisor   = full_next ? DIV_W'(WINDOW) : DIV_W'(slot_next);
    slot_d    = slot_q;
    full_d    = full_q;
    recip_d   = recip_q;
    valid_d   = valid_q && !pipe_ready_i;
    if (accept) begin
      slot_d  = slot_next;
      full_d  = full_next;
      recip_d = recip_tab[divisor];
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      full_q  <= 1'b0;
      recip_q <= '0;
      valid_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      full_q  <= full_d;
      recip_q <= recip_d;
      valid_q <= valid_d;
    end
  end

  assign lane_ctrl_o = '{wr_en: accept, slot: slot_q, recip: recip_q};

endmodule

// ===== design/mma_lane.sv =====
`timescale 1ns / 1ps

module mma_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mma_pkg::lane_ctrl_t           lane_ctrl_i,
  input  logic [mma_pkg::SAMPLE_W-1:0]  sample_i,
  output logic [mma_pkg::SAMPLE_W-1:0]  average_o,
  output logic [mma_pkg::SCALED_W-1:0]  scaled_o
);
  import mma_pkg::*;

  logic [SAMPLE_W-1:0]    hist_q [WINDOW];
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_W-1:0]    samp_q;
  logic [PROD_W-1:0]      quot_prod;
  logic [TERM_W-1:0]      term;
  logic [FRAC_PROD_W-1:0] frac_prod;

  assign sum_d = sum_q - SUM_W'(hist_q[lane_ctrl_i.slot]) + SUM_W'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        hist_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (lane_ctrl_i.wr_en) begin
      hist_q[lane_ctrl_i.slot] <= sample_i;
      sum_q                    <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lane_ctrl_i.wr_en) begin
      samp_q <= sample_i;
    end
  end

  // window mean by reciprocal multiply
  assign quot_prod = PROD_W'(sum_q) * PROD_W'(lane_ctrl_i.recip);
  assign average_o = SAMPLE_W'(quot_prod >> RECIP_SHIFT);

  // full-scale normalisation
  assign term      = TERM_W'(samp_q) << GAIN_SHIFT;
  assign frac_prod = FRAC_PROD_W'(term) * FRAC_PROD_W'(FRAC_RECIP);
  assign scaled_o  = SCALED_W'(term) + SCALED_W'(frac_prod >> FRAC_SHIFT);

endmodule

// ===== design/mma_merge.sv =====
`timescale 1ns / 1ps

module mma_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pipe_valid_i,
  output logic                          pipe_ready_o,
  input  logic [mma_pkg::SAMPLE_W-1:0]  average_i [mma_pkg::CHANNELS],
  input  logic [mma_pkg::SCALED_W-1:0]  scaled_i [mma_pkg::CHANNELS],
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mma_pkg::out_item_t            out_item_o
);
  import mma_pkg::*;

  logic      out_valid_q, out_valid_d;
  out_item_t item_q, item_d;
  logic      load;

  assign pipe_ready_o = !out_valid_q || out_ready_i;
  assign load         = pipe_valid_i && pipe_ready_o;

  always_comb begin
    item_d = '{
      average_ch0: average_i[0],
      average_ch1: average_i[1],
      average_ch2: average_i[2],
      average_ch3: average_i[3],
      scaled_ch0:  scaled_i[0],
      scaled_ch1:  scaled_i[1],
      scaled_ch2:  scaled_i[2],
      scaled_ch3:  scaled_i[3]
    };
    out_valid_d = load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = item_q;

endmodule

// ===== design/mma_checker.sv =====
`timescale 1ns / 1ps
`include "multichannel_moving_average_macros.svh"

module mma_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input mma_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input mma_pkg::out_item_t out_item_o
);
  import mma_pkg::*;

  logic scaled_ok;

  assign scaled_ok = (out_item_o.scaled_ch0 <= 16'd32768) && (out_item_o.scaled_ch1 <= 16'd32768) &&
                     (out_item_o.scaled_ch2 <= 16'd32768) && (out_item_o.scaled_ch3 <= 16'd32768);

  `MMA_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !out_valid_o, "result valid in reset")

  `MMA_ASSERT(a_stall_holds, out_valid_o && !out_ready_i |=> $stable(out_item_o), "stalled item changed")

  `MMA_ASSERT(a_result_has_cause, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2), "result without item")

  `MMA_ASSERT(a_scaled_range, out_valid_o |-> scaled_ok, "scaled above one")

endmodule

bind multichannel_moving_average mma_checker u_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mma_pkg::*;

  localparam int RANDOM_ROUNDS  = 880;
  localparam int LONG_HOLD      = 200;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DIRECTED_ROWS  = 17;

  typedef enum int {READY_ALWAYS, READY_HALF, READY_EVERY_THIRD, READY_MOSTLY} ready_mode_e;

  typedef struct packed {
    in_item_t  round;
    logic      pinned;
    out_item_t result;
  } directed_row_t;

  // pinned results follow straight from reset: first round divides by one, second by two
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{12'hFFF, 12'h000, 12'h001, 12'h800}, 1'b1,
      '{12'd4095, 12'd0, 12'd1, 12'd2048, 16'd32768, 16'd0, 16'd8, 16'd16388}},
    '{'{12'hFFF, 12'hFFF, 12'hFFE, 12'h001}, 1'b1,
      '{12'd4095, 12'd2047, 12'd2047, 12'd1024, 16'd32768, 16'd32768, 16'd32759, 16'd8}},
    '{'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 1'b0, '0},
    '{'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 1'b0, '0},
    '{'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 1'b0, '0},
    '{'{12'h000, 12'h000, 12'h000, 12'h000}, 1'b0, '0},
    '{'{12'hAAA, 12'h555, 12'h7FF, 12'h800}, 1'b0, '0},
    '{'{12'h555, 12'hAAA, 12'h800, 12'h7FF}, 1'b0, '0},
    '{'{12'h000, 12'hFFF, 12'h000, 12'hFFF}, 1'b0, '0},
    '{'{12'hFFF, 12'h000, 12'hFFF, 12'h000}, 1'b0, '0},
    '{'{12'h001, 12'hFFE, 12'h002, 12'hFFD}, 1'b0, '0},
    '{'{12'h000, 12'h000, 12'h000, 12'h000}, 1'b0, '0},
    '{'{12'h000, 12'h000, 12'h000, 12'h000}, 1'b0, '0},
    '{'{12'h000, 12'h000, 12'h000, 12'h000}, 1'b0, '0},
    '{'{12'h000, 12'h000, 12'h000, 12'h000}, 1'b0, '0},
    '{'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 1'b0, '0},
    '{'{12'h7FF, 12'h800, 12'h001, 12'hFFE}, 1'b0, '0}
  };

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // filter state
  logic [SAMPLE_W-1:0] sample_history [CHANNELS][WINDOW];
  logic [SUM_W-1:0]    window_sums [CHANNELS];
  int unsigned         write_pos    = 0;
  logic                history_full = 1'b0;

  out_item_t pending_results [$];
  int        mismatches    = 0;
  int        rounds_sent   = 0;
  int        results_seen  = 0;
  int        holds_done    = 0;
  int        input_stalls  = 0;
  int        idle_cycles   = 0;
  int        burst_left    = 0;

  multichannel_moving_average dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_item_t step_filter(in_item_t round);
    logic [SAMPLE_W-1:0] smp [CHANNELS];
    logic [SAMPLE_W-1:0] mean [CHANNELS];
    logic [SCALED_W-1:0] frac [CHANNELS];
    int unsigned         nxt;
    int unsigned         divisor;
    out_item_t           res;
    smp[0] = round.sample_ch0;
    smp[1] = round.sample_ch1;
    smp[2] = round.sample_ch2;
    smp[3] = round.sample_ch3;
    nxt = (write_pos + 1) % WINDOW;
    if (nxt == 0) history_full = 1'b1;
    divisor = history_full ? WINDOW : nxt;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      window_sums[ch] = window_sums[ch] - sample_history[ch][write_pos] + smp[ch];
      sample_history[ch][write_pos] = smp[ch];
      mean[ch] = SAMPLE_W'(int'(window_sums[ch]) / divisor);
      frac[ch] = SCALED_W'((int'(smp[ch]) * Q15_ONE) / FULL_SCALE);
    end
    write_pos = nxt;
    res.average_ch0 = mean[0];
    res.average_ch1 = mean[1];
    res.average_ch2 = mean[2];
    res.average_ch3 = mean[3];
    res.scaled_ch0  = frac[0];
    res.scaled_ch1  = frac[1];
    res.scaled_ch2  = frac[2];
    res.scaled_ch3  = frac[3];
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SAMPLE_W'(FULL_SCALE);
      2:       return SAMPLE_W'($urandom_range(0, 15));
      3:       return SAMPLE_W'($urandom_range(FULL_SCALE - 15, FULL_SCALE));
      default: return SAMPLE_W'($urandom_range(0, FULL_SCALE));
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  task automatic compare_field(string field, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
  endtask

  task automatic send_round(in_item_t round, logic pinned, out_item_t pinned_result);
    out_item_t predicted;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 40);
    end
    in_item  <= round;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    burst_left--;
    predicted = step_filter(round);
    pending_results.push_back(pinned ? pinned_result : predicted);
    rounds_sent++;
  endtask

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no round pending");
      end else begin
        want = pending_results.pop_front();
        compare_field("average_ch0", out_item.average_ch0, want.average_ch0);
        compare_field("average_ch1", out_item.average_ch1, want.average_ch1);
        compare_field("average_ch2", out_item.average_ch2, want.average_ch2);
        compare_field("average_ch3", out_item.average_ch3, want.average_ch3);
        compare_field("scaled_ch0", out_item.scaled_ch0, want.scaled_ch0);
        compare_field("scaled_ch1", out_item.scaled_ch1, want.scaled_ch1);
        compare_field("scaled_ch2", out_item.scaled_ch2, want.scaled_ch2);
        compare_field("scaled_ch3", out_item.scaled_ch3, want.scaled_ch3);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_ready) input_stalls++;
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // output side: stall pattern of its own, plus long holds to back the block up
  initial begin : drain_side
    ready_mode_e mode;
    int          seg;
    int          hold_points [2];
    hold_points = '{250, 650};
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holds_done < 2 && results_seen >= hold_points[holds_done]) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        holds_done++;
      end
      mode = ready_mode_e'($urandom_range(0, 3));
      seg  = $urandom_range(20, 120);
      for (int i = 0; i < seg; i++) begin
        case (mode)
          READY_ALWAYS:      out_ready <= 1'b1;
          READY_HALF:        out_ready <= 1'($urandom_range(0, 1));
          READY_EVERY_THIRD: out_ready <= (i % 3 == 0);
          default:           out_ready <= ($urandom_range(0, 9) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : source_side
    in_item_t round;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      window_sums[ch] = '0;
      for (int k = 0; k < WINDOW; k++) sample_history[ch][k] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_round(directed_rows[r].round, directed_rows[r].pinned, directed_rows[r].result);

    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      round.sample_ch0 = random_sample();
      round.sample_ch1 = random_sample();
      round.sample_ch2 = random_sample();
      round.sample_ch3 = random_sample();
      send_round(round, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d rounds filtered (%0d from the directed table), %0d results checked",
             rounds_sent, DIRECTED_ROWS, results_seen);
    $display("%0d long output holds, input held off on %0d cycles", holds_done, input_stalls);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
